[design/hlcp_pkg.sv]
// Shared types and constants for the hop-limited cheapest path block.
// Used by the controller, the datapath and the top level; depends on nothing.
package hlcp_pkg;

   localparam int MODE_W       = 2;
   localparam int NODE_ID_W    = 6;
   localparam int COST_IN_W    = 16;
   localparam int STOPS_W      = 6;
   localparam int NODE_COUNT_W = 7;
   localparam int RESULT_W     = 31;
   localparam int DIST_W       = 30;

   localparam int DEF_MAX_NODES = 64;
   localparam int DEF_MAX_EDGES = 256;
   localparam int DEF_COST_BITS = 16;

   localparam logic [DIST_W-1:0]       UNREACHED       = 30'd1000000010;
   localparam logic [DIST_W-1:0]       COST_CAP        = 30'd1000000009;
   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST  = 7'd64;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_COPY,
      ST_EDGES,
      ST_DRAIN,
      ST_ROUND_END,
      ST_FETCH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear_edges;
      logic add_edge;
      logic start_query;
      logic init_sweep;
      logic copy_sweep;
      logic edge_pass;
      logic round_end;
      logic fetch;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic query_bad;
      logic init_last;
      logic copy_last;
      logic edges_issued;
      logic pipe_empty;
      logic rounds_over;
      logic out_full;
   } status_type;

endpackage

[design/hlcp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the edge table and the per-node cost tables.
module hlcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/hlcp_ctrl.sv]
// Controller state machine for the hop-limited cheapest path block.
// Depends on hlcp_pkg; drives the datapath through cmd_type and reads status_type.
module hlcp_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hlcp_pkg::MODE_W-1:0]       req_mode,
   input  hlcp_pkg::status_type              status,
   output hlcp_pkg::cmd_type                 cmd
);

   import hlcp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_mode == MODE_QUERY)) begin
               state_in = status.query_bad ? ST_RESULT : ST_INIT;
            end
         end
         ST_INIT: begin
            if (status.init_last) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (status.copy_last) begin
               state_in = ST_EDGES;
            end
         end
         ST_EDGES: begin
            if (status.edges_issued) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = ST_ROUND_END;
            end
         end
         ST_ROUND_END: begin
            state_in = status.rounds_over ? ST_FETCH : ST_COPY;
         end
         ST_FETCH: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!status.out_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_mode)
                  MODE_CLEAR: cmd.clear_edges = 1'b1;
                  MODE_ADD:   cmd.add_edge    = 1'b1;
                  MODE_QUERY: cmd.start_query = 1'b1;
                  default:    cmd           = '0;
               endcase
            end
         end
         ST_INIT:      cmd.init_sweep  = 1'b1;
         ST_COPY:      cmd.copy_sweep  = 1'b1;
         ST_EDGES:     cmd.edge_pass   = 1'b1;
         ST_DRAIN:     cmd             = '0;
         ST_ROUND_END: cmd.round_end   = 1'b1;
         ST_FETCH:     cmd.fetch       = 1'b1;
         ST_RESULT:    cmd.load_result = !status.out_full;
         default:      cmd             = '0;
      endcase
   end

endmodule

[design/hlcp_datapath.sv]
// Datapath for the hop-limited cheapest path block: edge table, cost tables,
// relaxation pipeline, counters and the result register. Depends on hlcp_pkg, hlcp_ram.
module hlcp_datapath #(
   parameter int MAX_NODES = hlcp_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = hlcp_pkg::DEF_MAX_EDGES,
   parameter int COST_BITS = hlcp_pkg::DEF_COST_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hlcp_pkg::cmd_type                     cmd,
   output hlcp_pkg::status_type                  status,
   input  logic [hlcp_pkg::NODE_ID_W-1:0]        req_edge_from,
   input  logic [hlcp_pkg::NODE_ID_W-1:0]        req_edge_to,
   input  logic [hlcp_pkg::COST_IN_W-1:0]        req_edge_cost,
   input  logic [hlcp_pkg::NODE_ID_W-1:0]        req_source_node,
   input  logic [hlcp_pkg::NODE_ID_W-1:0]        req_target_node,
   input  logic [hlcp_pkg::STOPS_W-1:0]          req_max_stops,
   input  logic                                  csr_wr_en,
   input  logic [hlcp_pkg::NODE_COUNT_W-1:0]     csr_wr_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [hlcp_pkg::RESULT_W-1:0]  rsp_cheapest_cost,
   output logic                                  rsp_edges_dropped
);

   import hlcp_pkg::*;

   localparam int NA_W   = $clog2(MAX_NODES);
   localparam int CNT_W  = NA_W + 1;
   localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ET_W   = $clog2(MAX_EDGES + 1);
   localparam int EDGE_W = 2 * NODE_ID_W + COST_BITS;
   localparam int SUM_W  = DIST_W + 1;

   function automatic logic id_ok(input logic [NODE_ID_W-1:0]    id,
                                  input logic [NODE_COUNT_W-1:0] count);
      return (NODE_COUNT_W'(id) < count) && (32'(id) < MAX_NODES);
   endfunction

   // Configuration and edge table bookkeeping.
   logic [NODE_COUNT_W-1:0] node_count_ff;
   logic [ET_W-1:0]         edge_total_ff;
   logic                    overflow_ff;

   // Query context.
   logic [NA_W-1:0]         src_ff;
   logic [NA_W-1:0]         dst_ff;
   logic [STOPS_W-1:0]      stops_ff;
   logic                    bad_ff;
   logic [STOPS_W:0]        round_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [ET_W-1:0]         ecnt_ff;
   logic [MAX_NODES-1:0]    improved_ff;
   logic [MAX_NODES-1:0]    next_mark_ff;

   // Relaxation pipeline.
   logic                    s1_v_ff;
   logic                    s2_v_ff;
   logic [NA_W-1:0]         s2_b_ff;
   logic [COST_BITS-1:0]    s2_c_ff;
   logic                    fw_en_ff;
   logic [NA_W-1:0]         fw_addr_ff;
   logic [DIST_W-1:0]       fw_data_ff;

   // Result register.
   logic                        rsp_valid_ff;
   logic [RESULT_W-1:0]         rsp_cost_ff;
   logic                        rsp_dropped_ff;

   // Memory ports.
   logic                    edge_we;
   logic [EA_W-1:0]         edge_waddr;
   logic [EDGE_W-1:0]       edge_wdata;
   logic                    edge_issue;
   logic [EDGE_W-1:0]       edge_q;

   logic                    best_we;
   logic [NA_W-1:0]         best_waddr;
   logic [DIST_W-1:0]       best_wdata;
   logic                    best_re;
   logic [NA_W-1:0]         best_raddr;
   logic [DIST_W-1:0]       best_q;

   logic                    round_we;
   logic [DIST_W-1:0]       round_q;

   // Stage one and stage two signals.
   logic [NODE_ID_W-1:0]    s1_a;
   logic [NODE_ID_W-1:0]    s1_b;
   logic [NA_W-1:0]         s1_a_idx;
   logic [NA_W-1:0]         s1_b_idx;
   logic                    s1_pass;
   logic [DIST_W-1:0]       s2_old;
   logic [SUM_W-1:0]        s2_sum;
   logic [DIST_W-1:0]       s2_sat;
   logic                    better;
   logic [NA_W-1:0]         cnt_idx;
   logic [RESULT_W-1:0]     result_val;

   assign cnt_idx  = cnt_ff[NA_W-1:0];
   assign s1_a     = edge_q[EDGE_W-1 -: NODE_ID_W];
   assign s1_b     = edge_q[COST_BITS +: NODE_ID_W];
   assign s1_a_idx = NA_W'(s1_a);
   assign s1_b_idx = NA_W'(s1_b);
   assign s1_pass  = s1_v_ff && id_ok(s1_a, node_count_ff) && id_ok(s1_b, node_count_ff)
                     && improved_ff[s1_a_idx];

   assign s2_old = (fw_en_ff && (fw_addr_ff == s2_b_ff)) ? fw_data_ff : best_q;
   assign s2_sum = SUM_W'(round_q) + SUM_W'(s2_c_ff);
   assign s2_sat = (s2_sum > SUM_W'(COST_CAP)) ? COST_CAP : s2_sum[DIST_W-1:0];
   assign better = s2_v_ff && (s2_sat < s2_old);

   assign edge_issue = cmd.edge_pass && (ecnt_ff < edge_total_ff);
   assign edge_we    = cmd.add_edge && (edge_total_ff < ET_W'(MAX_EDGES));
   assign edge_waddr = edge_total_ff[EA_W-1:0];
   assign edge_wdata = {req_edge_from, req_edge_to, COST_BITS'(req_edge_cost)};

   always_comb begin
      best_re    = 1'b0;
      best_raddr = cnt_idx;
      if (cmd.copy_sweep) begin
         best_re    = cnt_ff < CNT_W'(MAX_NODES);
         best_raddr = cnt_idx;
      end else if (s1_pass) begin
         best_re    = 1'b1;
         best_raddr = s1_b_idx;
      end else if (cmd.fetch) begin
         best_re    = 1'b1;
         best_raddr = dst_ff;
      end
   end

   always_comb begin
      best_we    = 1'b0;
      best_waddr = s2_b_ff;
      best_wdata = s2_sat;
      if (cmd.init_sweep) begin
         best_we    = 1'b1;
         best_waddr = cnt_idx;
         best_wdata = (cnt_idx == src_ff) ? '0 : UNREACHED;
      end else if (better) begin
         best_we    = 1'b1;
      end
   end

   assign round_we = cmd.copy_sweep && (cnt_ff != '0);

   hlcp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (edge_wdata),
      .rd_en   (edge_issue),
      .rd_addr (ecnt_ff[EA_W-1:0]),
      .rd_data (edge_q)
   );

   hlcp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_best_ram (
      .clock   (clock),
      .wr_en   (best_we),
      .wr_addr (best_waddr),
      .wr_data (best_wdata),
      .rd_en   (best_re),
      .rd_addr (best_raddr),
      .rd_data (best_q)
   );

   hlcp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_round_ram (
      .clock   (clock),
      .wr_en   (round_we),
      .wr_addr (NA_W'(cnt_ff - 1'b1)),
      .wr_data (best_q),
      .rd_en   (s1_pass),
      .rd_addr (s1_a_idx),
      .rd_data (round_q)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
         round_ff      <= '0;
         cnt_ff        <= '0;
         ecnt_ff       <= '0;
         improved_ff   <= '0;
         next_mark_ff  <= '0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         fw_en_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (cmd.clear_edges) begin
            edge_total_ff <= '0;
            overflow_ff   <= 1'b0;
         end else if (cmd.add_edge) begin
            if (edge_we) begin
               edge_total_ff <= edge_total_ff + 1'b1;
            end else begin
               overflow_ff <= 1'b1;
            end
         end

         if (cmd.start_query) begin
            round_ff     <= '0;
            cnt_ff       <= '0;
            improved_ff  <= {{(MAX_NODES-1){1'b0}}, 1'b1} << NA_W'(req_source_node);
            next_mark_ff <= '0;
         end else if (cmd.init_sweep) begin
            cnt_ff <= status.init_last ? '0 : cnt_ff + 1'b1;
         end else if (cmd.copy_sweep) begin
            cnt_ff  <= status.copy_last ? '0 : cnt_ff + 1'b1;
            ecnt_ff <= '0;
         end else if (cmd.round_end) begin
            round_ff     <= round_ff + 1'b1;
            improved_ff  <= next_mark_ff;
            next_mark_ff <= '0;
         end

         if (edge_issue) begin
            ecnt_ff <= ecnt_ff + 1'b1;
         end
         if (better) begin
            next_mark_ff[s2_b_ff] <= 1'b1;
         end

         s1_v_ff  <= edge_issue;
         s2_v_ff  <= s1_pass;
         fw_en_ff <= better;

         if (cmd.load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign result_val = (bad_ff || (best_q >= UNREACHED)) ? '1 : RESULT_W'(best_q);

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         src_ff   <= NA_W'(req_source_node);
         dst_ff   <= NA_W'(req_target_node);
         stops_ff <= req_max_stops;
         bad_ff   <= status.query_bad;
      end
      s2_b_ff    <= s1_b_idx;
      s2_c_ff    <= edge_q[COST_BITS-1:0];
      fw_addr_ff <= s2_b_ff;
      fw_data_ff <= s2_sat;
      if (cmd.load_result) begin
         rsp_cost_ff    <= result_val;
         rsp_dropped_ff <= overflow_ff;
      end
   end

   always_comb begin
      status              = '0;
      status.query_bad    = !(id_ok(req_source_node, node_count_ff)
                              && id_ok(req_target_node, node_count_ff));
      status.init_last    = cnt_ff == CNT_W'(MAX_NODES - 1);
      status.copy_last    = cnt_ff == CNT_W'(MAX_NODES);
      status.edges_issued = ecnt_ff == edge_total_ff;
      status.pipe_empty   = !s1_v_ff && !s2_v_ff;
      status.rounds_over  = (round_ff == {1'b0, stops_ff}) || (next_mark_ff == '0);
      status.out_full     = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cheapest_cost = signed'(rsp_cost_ff);
   assign rsp_edges_dropped = rsp_dropped_ff;

endmodule

[design/hop_limited_cheapest_path.sv]
// Top level of the hop-limited cheapest path block (rounds of edge relaxation).
// Depends on hlcp_pkg, hlcp_ctrl and hlcp_datapath.
//
//   channel   ports                         direction   handshake
//   request   req_mode .. req_max_stops     in          req_valid / req_ready
//   response  rsp_cheapest_cost, dropped    out         rsp_valid / rsp_ready
//   config    csr_wr_data (node_count)      in          csr_wr_en, no wait
//
// Clear and add-edge words are taken without leaving the idle state.
// A query runs an initialising sweep of the per-node cost memory, then rounds of a copy
// sweep into the round snapshot and a pass over the E stored edges; it stops after
// max_stops + 1 rounds or after a round that improves no node.
// A query whose endpoints lie outside the node count goes to its result without any rounds.
// Reset is synchronous; no clearing pass is needed. A pending response word stalls
// the loading of the next query result, and no request is taken while that result waits.
module hop_limited_cheapest_path #(
   parameter int MAX_NODES = hlcp_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = hlcp_pkg::DEF_MAX_EDGES,
   parameter int COST_BITS = hlcp_pkg::DEF_COST_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [hlcp_pkg::MODE_W-1:0]           req_mode,
   input  logic [hlcp_pkg::NODE_ID_W-1:0]        req_edge_from,
   input  logic [hlcp_pkg::NODE_ID_W-1:0]        req_edge_to,
   input  logic [hlcp_pkg::COST_IN_W-1:0]        req_edge_cost,
   input  logic [hlcp_pkg::NODE_ID_W-1:0]        req_source_node,
   input  logic [hlcp_pkg::NODE_ID_W-1:0]        req_target_node,
   input  logic [hlcp_pkg::STOPS_W-1:0]          req_max_stops,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [hlcp_pkg::RESULT_W-1:0]  rsp_cheapest_cost,
   output logic                                  rsp_edges_dropped,
   input  logic                                  csr_wr_en,
   input  logic [hlcp_pkg::NODE_COUNT_W-1:0]     csr_wr_data
);

   import hlcp_pkg::*;

   cmd_type    cmd;
   status_type status;

   hlcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd)
   );

   hlcp_datapath #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES),
      .COST_BITS (COST_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_edge_from     (req_edge_from),
      .req_edge_to       (req_edge_to),
      .req_edge_cost     (req_edge_cost),
      .req_source_node   (req_source_node),
      .req_target_node   (req_target_node),
      .req_max_stops     (req_max_stops),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_cheapest_cost (rsp_cheapest_cost),
      .rsp_edges_dropped (rsp_edges_dropped)
   );

endmodule

[bench/hop_limited_cheapest_path_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for hop_limited_cheapest_path: loads edge tables, clears and queries,
// predicts every query answer from its own edge table and compares each response word.
// Depends on hlcp_pkg and the design sources of hop_limited_cheapest_path.
module hop_limited_cheapest_path_tb;
   import hlcp_pkg::*;

   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
   localparam int EDGE_SLOTS = DEF_MAX_EDGES;
   localparam int NODE_SLOTS = DEF_MAX_NODES;
   localparam int RANDOM_WORDS = 600;
   localparam logic [RESULT_W-1:0] NO_PATH = '1;

   typedef struct {
      logic [MODE_W-1:0]    mode;
      logic [NODE_ID_W-1:0] from_node;
      logic [NODE_ID_W-1:0] to_node;
      logic [COST_IN_W-1:0] cost;
      logic [NODE_ID_W-1:0] src;
      logic [NODE_ID_W-1:0] dst;
      logic [STOPS_W-1:0]   stops;
   } path_req_type;

   typedef struct {
      logic [RESULT_W-1:0] cost;
      logic                dropped;
   } path_answer_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [MODE_W-1:0]           req_mode = '0;
   logic [NODE_ID_W-1:0]        req_edge_from = '0;
   logic [NODE_ID_W-1:0]        req_edge_to = '0;
   logic [COST_IN_W-1:0]        req_edge_cost = '0;
   logic [NODE_ID_W-1:0]        req_source_node = '0;
   logic [NODE_ID_W-1:0]        req_target_node = '0;
   logic [STOPS_W-1:0]          req_max_stops = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [RESULT_W-1:0]  rsp_cheapest_cost;
   logic                        rsp_edges_dropped;
   logic                        csr_wr_en = 1'b0;
   logic [NODE_COUNT_W-1:0]     csr_wr_data = '0;

   path_req_type    request_backlog[$];
   path_answer_type answer_queue[$];
   path_req_type    in_flight;
   path_answer_type oldest;
   int unsigned  words_queued = 0;
   int unsigned  words_taken = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  stall_pct = 29;

   logic [NODE_ID_W-1:0]    link_from [EDGE_SLOTS];
   logic [NODE_ID_W-1:0]    link_to [EDGE_SLOTS];
   logic [COST_IN_W-1:0]    link_cost [EDGE_SLOTS];
   int unsigned             link_fill = 0;
   logic                    drop_seen = 1'b0;
   logic [NODE_COUNT_W-1:0] node_limit = NODE_COUNT_RST;

   hop_limited_cheapest_path DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_edge_from     (req_edge_from),
      .req_edge_to       (req_edge_to),
      .req_edge_cost     (req_edge_cost),
      .req_source_node   (req_source_node),
      .req_target_node   (req_target_node),
      .req_max_stops     (req_max_stops),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cheapest_cost (rsp_cheapest_cost),
      .rsp_edges_dropped (rsp_edges_dropped),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [RESULT_W-1:0] cheapest_within_hops(
      input logic [NODE_ID_W-1:0] src,
      input logic [NODE_ID_W-1:0] dst,
      input logic [STOPS_W-1:0]   stops
   );
      logic [DIST_W-1:0] best [NODE_SLOTS];
      logic [DIST_W-1:0] snap [NODE_SLOTS];
      bit                mark [NODE_SLOTS];
      bit                next_mark [NODE_SLOTS];
      logic [DIST_W:0]   sum;
      int unsigned       live, hop, v, e;
      bit                moved;
      live = (node_limit > NODE_SLOTS) ? NODE_SLOTS : node_limit;
      if (src >= live || dst >= live) return NO_PATH;
      for (v = 0; v < NODE_SLOTS; v++) begin
         best[v] = UNREACHED;
         mark[v] = 1'b0;
      end
      best[src] = '0;
      mark[src] = 1'b1;
      moved = 1'b1;
      // Each round relaxes from the costs frozen at the end of the previous round.
      for (hop = 0; hop <= stops && moved; hop++) begin
         for (v = 0; v < NODE_SLOTS; v++) begin
            snap[v] = best[v];
            next_mark[v] = 1'b0;
         end
         for (e = 0; e < link_fill; e++) begin
            if (link_from[e] < live && link_to[e] < live && mark[link_from[e]]) begin
               sum = snap[link_from[e]] + link_cost[e];
               if (sum > COST_CAP) sum = COST_CAP;
               if (sum < best[link_to[e]]) begin
                  best[link_to[e]] = sum[DIST_W-1:0];
                  next_mark[link_to[e]] = 1'b1;
               end
            end
         end
         moved = 1'b0;
         for (v = 0; v < NODE_SLOTS; v++) begin
            mark[v] = next_mark[v];
            if (next_mark[v]) moved = 1'b1;
         end
      end
      if (best[dst] >= UNREACHED) return NO_PATH;
      return {1'b0, best[dst]};
   endfunction

   function automatic void apply_word(input path_req_type w);
      path_answer_type answer;
      case (w.mode)
         MODE_CLEAR: begin
            link_fill = 0;
            drop_seen = 1'b0;
         end
         MODE_ADD: begin
            if (link_fill >= EDGE_SLOTS) begin
               drop_seen = 1'b1;
            end else begin
               link_from[link_fill] = w.from_node;
               link_to[link_fill] = w.to_node;
               link_cost[link_fill] = w.cost;
               link_fill++;
            end
         end
         MODE_QUERY: begin
            answer.cost = cheapest_within_hops(w.src, w.dst, w.stops);
            answer.dropped = drop_seen;
            answer_queue.insert(answer_queue.size(), answer);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_word(in_flight);
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= stall_pct) begin
               in_flight = request_backlog.pop_front();
               req_valid <= 1'b1;
               req_mode <= in_flight.mode;
               req_edge_from <= in_flight.from_node;
               req_edge_to <= in_flight.to_node;
               req_edge_cost <= in_flight.cost;
               req_source_node <= in_flight.src;
               req_target_node <= in_flight.dst;
               req_max_stops <= in_flight.stops;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_queue.size() == 0) begin
               report_mismatch($sformatf("response word with no query waiting, cost %0d",
                                         rsp_cheapest_cost));
            end else begin
               oldest = answer_queue.pop_front();
               if (rsp_cheapest_cost !== oldest.cost)
                  report_mismatch($sformatf("cheapest_cost mismatch: got %0d, expected %0d",
                                            rsp_cheapest_cost, $signed(oldest.cost)));
               if (rsp_edges_dropped !== oldest.dropped)
                  report_mismatch($sformatf("edges_dropped mismatch: got %0b, expected %0b",
                                            rsp_edges_dropped, oldest.dropped));
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic path_req_type scrambled_word(input logic [MODE_W-1:0] mode);
      path_req_type w;
      w.mode = mode;
      w.from_node = NODE_ID_W'($urandom_range(63));
      w.to_node = NODE_ID_W'($urandom_range(63));
      w.cost = COST_IN_W'($urandom_range(65535));
      w.src = NODE_ID_W'($urandom_range(63));
      w.dst = NODE_ID_W'($urandom_range(63));
      w.stops = STOPS_W'($urandom_range(63));
      return w;
   endfunction

   task automatic queue_word(input path_req_type w);
      request_backlog.insert(request_backlog.size(), w);
      words_queued++;
   endtask

   task automatic queue_clear();
      queue_word(scrambled_word(MODE_CLEAR));
   endtask

   task automatic queue_edge(input int unsigned from_node, input int unsigned to_node,
                             input int unsigned cost);
      path_req_type w;
      w = scrambled_word(MODE_ADD);
      w.from_node = NODE_ID_W'(from_node);
      w.to_node = NODE_ID_W'(to_node);
      w.cost = COST_IN_W'(cost);
      queue_word(w);
   endtask

   task automatic queue_query(input int unsigned src, input int unsigned dst,
                              input int unsigned stops);
      path_req_type w;
      w = scrambled_word(MODE_QUERY);
      w.src = NODE_ID_W'(src);
      w.dst = NODE_ID_W'(dst);
      w.stops = STOPS_W'(stops);
      queue_word(w);
   endtask

   // Waits until every word is taken and answered, then lets a clear or add settle.
   task automatic drain_all();
      while (words_taken != words_queued || answer_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [NODE_COUNT_W-1:0] count);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      node_limit = count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [NODE_ID_W-1:0] pick_node(input int unsigned span);
      if ($urandom_range(9) == 0) return NODE_ID_W'($urandom_range(63));
      return NODE_ID_W'($urandom_range(span - 1));
   endfunction

   function automatic logic [STOPS_W-1:0] pick_stops();
      if ($urandom_range(7) == 0)
         return ($urandom_range(1) != 0) ? STOPS_W'(63) : STOPS_W'($urandom_range(63));
      return STOPS_W'($urandom_range(7));
   endfunction

   function automatic logic [COST_IN_W-1:0] pick_cost();
      if ($urandom_range(1) != 0) return COST_IN_W'($urandom_range(65535));
      return COST_IN_W'($urandom_range(20));
   endfunction

   initial begin
      int unsigned             phase, random_words, span, usable, edges_left, queries_left;
      logic [NODE_COUNT_W-1:0] count;
      bit                      overflow_phase, mixed;
      path_req_type            w;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      queue_query(0, 0, 0);
      queue_query(0, 63, 63);
      queue_edge(0, 1, 65535);
      queue_edge(1, 2, 0);
      queue_edge(2, 63, 1);
      queue_edge(63, 0, 7);
      queue_edge(0, 2, 65535);
      queue_query(0, 2, 0);
      queue_query(0, 2, 1);
      queue_query(0, 63, 0);
      queue_query(0, 63, 1);
      queue_query(63, 63, 63);
      queue_query(63, 2, 63);
      w = scrambled_word(MODE_IGNORED);
      w.from_node = '1;
      w.to_node = '1;
      w.cost = '1;
      w.src = '1;
      w.dst = '1;
      w.stops = '1;
      queue_word(w);
      queue_query(1, 0, 2);
      queue_clear();
      queue_query(0, 2, 5);
      queue_edge(42, 21, 21845);
      queue_edge(21, 42, 43690);
      queue_query(42, 21, 42);
      queue_query(21, 42, 21);
      drain_all();

      phase = 0;
      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         case (phase)
            0: count = NODE_COUNT_W'(0);
            1: count = NODE_COUNT_W'(127);
            2: count = NODE_COUNT_W'(1);
            3: count = NODE_COUNT_W'(64);
            4: count = NODE_COUNT_W'(2);
            default: count = ($urandom_range(15) == 0) ? NODE_COUNT_W'(0)
                                                       : NODE_COUNT_W'($urandom_range(1, 127));
         endcase
         write_node_count(count);
         usable = (count == 0) ? 1 : ((count > NODE_SLOTS) ? NODE_SLOTS : count);
         span = (usable > 12 && $urandom_range(3) != 0) ? $urandom_range(2, 12) : usable;
         overflow_phase = (phase == 6);
         mixed = ($urandom_range(3) == 0);
         stall_pct = overflow_phase ? 0 : 29;
         if (overflow_phase || $urandom_range(7) != 0) begin
            queue_clear();
            random_words++;
         end
         edges_left = overflow_phase ? EDGE_SLOTS + $urandom_range(1, 6) : $urandom_range(1, 30);
         queries_left = $urandom_range(2, 8);
         while (edges_left + queries_left != 0) begin
            if ($urandom_range(19) == 0) queue_word(scrambled_word(MODE_IGNORED));
            if (edges_left != 0 && (queries_left == 0 || !mixed || $urandom_range(2) != 0)) begin
               if (!overflow_phase && $urandom_range(59) == 0) queue_clear();
               else queue_edge(pick_node(span), pick_node(span), pick_cost());
               edges_left--;
            end else begin
               queue_query(pick_node(span), pick_node(span), pick_stops());
               queries_left--;
            end
            random_words++;
         end
         drain_all();
         phase++;
      end

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
